### src/drs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_pkg: shared constants and types for running duration statistics
// Field widths, fixed-point format, mode codes and controller states.
// ----------------------------------------------------------------------------
package drs_pkg;

   localparam int TIME_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   localparam int MODE_W   = 3;
   localparam int SAMPLE_W = 32;
   localparam int MEAN_W   = 48;
   localparam int SSD_W    = 64;
   localparam int CNT_W    = 32;
   localparam int WORD_W   = 64;
   localparam int DVS_W    = CNT_W;
   localparam int PROD_W   = 2 * WORD_W;
   localparam int ROOT_W   = 48;
   localparam int RAD_W    = 2 * ROOT_W;

   localparam logic [SAMPLE_W-1:0] TIME_MASK =
      (TIME_WIDTH >= SAMPLE_W) ? {SAMPLE_W{1'b1}}
                               : SAMPLE_W'((64'd1 << TIME_WIDTH) - 64'd1);

   localparam logic [MODE_W-1:0] MODE_START = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_STOP  = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_ADD   = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_PAIR  = MODE_W'(3);
   localparam logic [MODE_W-1:0] MODE_CLEAR = MODE_W'(4);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MDIV_GO,
      ST_MDIV_WAIT,
      ST_MEAN,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_SSD,
      ST_VDIV_GO,
      ST_VDIV_WAIT,
      ST_VAR,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DONE
   } drs_state_type;

endpackage

### src/drs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_req_if: request channel
// Valid/ready channel carrying one timing command per transfer.
// ----------------------------------------------------------------------------
interface drs_req_if;
   logic                          valid;
   logic                          ready;
   logic [drs_pkg::MODE_W-1:0]    mode;
   logic [drs_pkg::SAMPLE_W-1:0]  start_us;
   logic [drs_pkg::SAMPLE_W-1:0]  stop_us;
   logic [drs_pkg::SAMPLE_W-1:0]  duration_us;

   modport source (output valid, output mode, output start_us, output stop_us,
                   output duration_us, input ready);
   modport sink   (input valid, input mode, input start_us, input stop_us,
                   input duration_us, output ready);
endinterface

### src/drs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_rsp_if: response channel
// Valid/ready channel carrying the statistics snapshot of one command.
// ----------------------------------------------------------------------------
interface drs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          sample_taken;
   logic [drs_pkg::SAMPLE_W-1:0]  last_us;
   logic [drs_pkg::MEAN_W-1:0]    mean_fixed;
   logic [drs_pkg::MEAN_W-1:0]    stddev_fixed;
   logic [drs_pkg::CNT_W-1:0]     sample_count;

   modport source (output valid, output sample_taken, output last_us,
                   output mean_fixed, output stddev_fixed, output sample_count,
                   input ready);
   modport sink   (input valid, input sample_taken, input last_us,
                   input mean_fixed, input stddev_fixed, input sample_count,
                   output ready);
endinterface

### src/drs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_div: bit-serial restoring divider
// Divides a WORD_W dividend by a DVS_W divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [drs_pkg::WORD_W-1:0]    dividend,
   input  logic [drs_pkg::DVS_W-1:0]     divisor,
   output logic                          done,
   output logic [drs_pkg::WORD_W-1:0]    quotient,
   output logic [drs_pkg::DVS_W-1:0]     remainder
);
   localparam int N  = drs_pkg::WORD_W;
   localparam int DW = drs_pkg::DVS_W;
   localparam int CW = $clog2(N);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [N-1:0]  quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dvs_ff, dvs_in;
   logic [DW:0]   trial;
   logic          ge;

   assign trial = {rem_ff, quo_ff[N-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(N - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         quo_in = {quo_ff[N-2:0], ge};
         rem_in = ge ? DW'(trial - {1'b0, dvs_ff}) : trial[DW-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

### src/drs_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_mul: bit-serial shift-add multiplier
// Forms a * b + c, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module drs_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [drs_pkg::WORD_W-1:0]    a,
   input  logic [drs_pkg::WORD_W-1:0]    b,
   input  logic [drs_pkg::WORD_W-1:0]    c,
   output logic                          done,
   output logic [drs_pkg::PROD_W-1:0]    product
);
   localparam int N  = drs_pkg::WORD_W;
   localparam int CW = $clog2(N);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [N-1:0]  a_ff, a_in;
   logic [N-1:0]  hi_ff, hi_in;
   logic [N-1:0]  lo_ff, lo_in;
   logic [N:0]    sum;

   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (start) begin
         // the addend starts in the high half and lands at bit 0 after N shifts
         busy_in = 1'b1;
         cnt_in  = CW'(N - 1);
         a_in    = a;
         hi_in   = c;
         lo_in   = b;
      end else if (busy_ff) begin
         hi_in  = sum[N:1];
         lo_in  = {sum[0], lo_ff[N-1:1]};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};
endmodule

### src/drs_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drs_sqrt: digit-serial integer square root
// Floor square root of a RAD_W radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
module drs_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [drs_pkg::RAD_W-1:0]     radicand,
   output logic                          done,
   output logic [drs_pkg::ROOT_W-1:0]    root
);
   localparam int RW = drs_pkg::ROOT_W;
   localparam int DW = drs_pkg::RAD_W;
   localparam int CW = $clog2(RW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rad_ff, rad_in;
   logic [RW:0]   rem_ff, rem_in;
   logic [RW-1:0] root_ff, root_in;
   logic [RW+2:0] trial_rem;
   logic [RW+2:0] trial;
   logic          ge;

   assign trial_rem = {rem_ff, rad_ff[DW-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign ge        = (trial_rem >= trial);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(RW - 1);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         // bring down two radicand bits, try the next root bit
         rad_in  = {rad_ff[DW-3:0], 2'b00};
         rem_in  = ge ? (RW + 1)'(trial_rem - trial) : trial_rem[RW:0];
         root_in = {root_ff[RW-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

### src/duration_running_statistics_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duration_running_statistics_top: running duration statistics
// Start/stop timing, Welford mean and squared-deviation update, and
// sample standard deviation in unsigned fixed point.
// ----------------------------------------------------------------------------
//  channel    dir  port      payload
//  request    in   req_chan  mode, start_us, stop_us, duration_us
//  response   out  rsp_chan  sample_taken, last_us, mean_fixed,
//                            stddev_fixed, sample_count
//
//  A command that takes no sample goes straight to the done state. One that
//  takes a sample runs a 64-step serial division (mean step), a 64-step serial
//  multiply and, once two samples are held, a second 64-step division (variance)
//  and a 48-step serial square root, each with its own go and wait states.
//  One command is in work at a time; req_chan.ready is high only when idle.
//  The response register holds a result until taken, while the next command
//  is accepted; finishing stalls only while that register is still full.
//  Reset is synchronous and clears all statistics.
// ----------------------------------------------------------------------------
module duration_running_statistics_top (
   input  logic      clock,
   input  logic      reset,
   drs_req_if.sink   req_chan,
   drs_rsp_if.source rsp_chan
);
   localparam int SW = drs_pkg::SAMPLE_W;
   localparam int MW = drs_pkg::MEAN_W;
   localparam int QW = drs_pkg::SSD_W;
   localparam int CW = drs_pkg::CNT_W;
   localparam int WW = drs_pkg::WORD_W;
   localparam int PW = drs_pkg::PROD_W;
   localparam int RW = drs_pkg::ROOT_W;
   localparam int F  = drs_pkg::FRAC_BITS;

   function automatic logic [SW-1:0] pair_sample(input logic [SW-1:0] t0,
                                                 input logic [SW-1:0] t1);
      logic [SW:0] diff;
      diff = {1'b0, t1 & drs_pkg::TIME_MASK} - {1'b0, t0 & drs_pkg::TIME_MASK};
      if (drs_pkg::TIME_WIDTH > SW && diff[SW])
         pair_sample = '1;
      else
         pair_sample = diff[SW-1:0] & drs_pkg::TIME_MASK;
   endfunction

   drs_pkg::drs_state_type state_ff, state_in;

   // statistics state
   logic [SW-1:0] last_ff, last_in;
   logic [CW-1:0] count_ff, count_in;
   logic [MW-1:0] mean_ff, mean_in;
   logic [QW-1:0] ssd_ff, ssd_in;
   logic          pending_ff, pending_in;
   logic [SW-1:0] start_time_ff, start_time_in;
   logic [RW-1:0] stddev_ff, stddev_in;

   // working registers
   logic          taken_ff, taken_in;
   logic [SW-1:0] s_ff, s_in;
   logic          below_ff, below_in;
   logic [WW-1:0] d1_ff, d1_in;
   logic [QW-1:0] var_ff, var_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_taken_ff;
   logic [SW-1:0] rsp_last_ff;
   logic [MW-1:0] rsp_mean_ff;
   logic [MW-1:0] rsp_stddev_ff;
   logic [CW-1:0] rsp_count_ff;
   logic          rsp_load;

   logic          accept;
   logic          take_sample;
   logic [WW-1:0] x_word;
   logic [WW-1:0] mean_word;
   logic [WW-1:0] new_mean;
   logic [PW-1:0] product;
   logic [WW-1:0] ssd_inc;
   logic [QW:0]   ssd_sum;
   logic [CW:0]   rem_twice;

   logic                    div_start, div_done;
   logic [WW-1:0]           div_dividend, div_quo;
   logic [drs_pkg::DVS_W-1:0] div_divisor, div_rem;
   logic                    mul_start, mul_done;
   logic [WW-1:0]           mul_b;
   logic                    sqrt_start, sqrt_done;
   logic [drs_pkg::RAD_W-1:0] sqrt_rad;
   logic [RW-1:0]           sqrt_root;

   assign req_chan.ready = (state_ff == drs_pkg::ST_IDLE);
   assign accept         = req_chan.valid & req_chan.ready;
   assign take_sample    = (req_chan.mode == drs_pkg::MODE_ADD) ||
                           (req_chan.mode == drs_pkg::MODE_PAIR) ||
                           (req_chan.mode == drs_pkg::MODE_STOP && pending_ff);

   assign x_word    = WW'(s_ff) << F;
   assign mean_word = WW'(mean_ff);
   assign new_mean  = below_ff ? mean_word - div_quo : mean_word + div_quo;
   assign ssd_inc   = (|product[PW-1:WW+F]) ? '1 : product[WW+F-1:F];
   assign ssd_sum   = {1'b0, ssd_ff} + {1'b0, ssd_inc};
   assign rem_twice = {div_rem, 1'b0};
   assign sqrt_rad  = drs_pkg::RAD_W'(var_ff) << F;
   assign mul_b     = (x_word >= mean_word) ? x_word - mean_word : mean_word - x_word;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         drs_pkg::ST_IDLE:
            if (accept) state_in = take_sample ? drs_pkg::ST_PREP : drs_pkg::ST_DONE;
         drs_pkg::ST_PREP:      state_in = drs_pkg::ST_MDIV_GO;
         drs_pkg::ST_MDIV_GO:   state_in = drs_pkg::ST_MDIV_WAIT;
         drs_pkg::ST_MDIV_WAIT: if (div_done) state_in = drs_pkg::ST_MEAN;
         drs_pkg::ST_MEAN:      state_in = drs_pkg::ST_MUL_GO;
         drs_pkg::ST_MUL_GO:    state_in = drs_pkg::ST_MUL_WAIT;
         drs_pkg::ST_MUL_WAIT:  if (mul_done) state_in = drs_pkg::ST_SSD;
         drs_pkg::ST_SSD:
            state_in = (count_ff >= CW'(2)) ? drs_pkg::ST_VDIV_GO : drs_pkg::ST_DONE;
         drs_pkg::ST_VDIV_GO:   state_in = drs_pkg::ST_VDIV_WAIT;
         drs_pkg::ST_VDIV_WAIT: if (div_done) state_in = drs_pkg::ST_VAR;
         drs_pkg::ST_VAR:       state_in = drs_pkg::ST_SQRT_GO;
         drs_pkg::ST_SQRT_GO:   state_in = drs_pkg::ST_SQRT_WAIT;
         drs_pkg::ST_SQRT_WAIT: if (sqrt_done) state_in = drs_pkg::ST_DONE;
         drs_pkg::ST_DONE:
            if (!rsp_valid_ff || rsp_chan.ready) state_in = drs_pkg::ST_IDLE;
         default:               state_in = drs_pkg::ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      last_in       = last_ff;
      count_in      = count_ff;
      mean_in       = mean_ff;
      ssd_in        = ssd_ff;
      pending_in    = pending_ff;
      start_time_in = start_time_ff;
      stddev_in     = stddev_ff;
      taken_in      = taken_ff;
      s_in          = s_ff;
      below_in      = below_ff;
      d1_in         = d1_ff;
      var_in        = var_ff;
      rsp_load      = 1'b0;
      div_start     = 1'b0;
      div_dividend  = ssd_ff;
      div_divisor   = count_ff - CW'(1);
      mul_start     = 1'b0;
      sqrt_start    = 1'b0;
      unique case (state_ff)
         drs_pkg::ST_IDLE: begin
            if (accept) begin
               taken_in = take_sample;
               unique case (req_chan.mode)
                  drs_pkg::MODE_START: begin
                     start_time_in = req_chan.start_us & drs_pkg::TIME_MASK;
                     pending_in    = 1'b1;
                  end
                  drs_pkg::MODE_STOP: begin
                     s_in       = pair_sample(start_time_ff, req_chan.stop_us);
                     pending_in = 1'b0;
                  end
                  drs_pkg::MODE_ADD:  s_in = req_chan.duration_us;
                  drs_pkg::MODE_PAIR: s_in = pair_sample(req_chan.start_us, req_chan.stop_us);
                  drs_pkg::MODE_CLEAR: begin
                     last_in       = '0;
                     count_in      = '0;
                     mean_in       = '0;
                     ssd_in        = '0;
                     pending_in    = 1'b0;
                     start_time_in = '0;
                     stddev_in     = '0;
                  end
                  default: ;
               endcase
            end
         end
         drs_pkg::ST_PREP: begin
            last_in  = s_ff;
            count_in = (count_ff != '1) ? count_ff + CW'(1) : count_ff;
            below_in = (x_word < mean_word);
            d1_in    = (x_word < mean_word) ? mean_word - x_word : x_word - mean_word;
         end
         drs_pkg::ST_MDIV_GO: begin
            // round to nearest: add half the divisor first
            div_start    = 1'b1;
            div_dividend = d1_ff + WW'(count_ff >> 1);
            div_divisor  = count_ff;
         end
         drs_pkg::ST_MDIV_WAIT: ;
         drs_pkg::ST_MEAN:
            mean_in = (|new_mean[WW-1:MW]) ? '1 : new_mean[MW-1:0];
         drs_pkg::ST_MUL_GO:    mul_start = 1'b1;
         drs_pkg::ST_MUL_WAIT:  ;
         drs_pkg::ST_SSD: begin
            ssd_in = ssd_sum[QW] ? '1 : ssd_sum[QW-1:0];
            if (count_ff < CW'(2)) stddev_in = '0;
         end
         drs_pkg::ST_VDIV_GO:   div_start = 1'b1;
         drs_pkg::ST_VDIV_WAIT: ;
         drs_pkg::ST_VAR:
            var_in = div_quo + WW'(rem_twice >= {1'b0, count_ff - CW'(1)});
         drs_pkg::ST_SQRT_GO:   sqrt_start = 1'b1;
         drs_pkg::ST_SQRT_WAIT: if (sqrt_done) stddev_in = sqrt_root;
         drs_pkg::ST_DONE:      rsp_load = !rsp_valid_ff || rsp_chan.ready;
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_chan.ready);

   drs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   drs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (d1_ff),
      .b       (mul_b),
      .c       (WW'(1) << (F - 1)),
      .done    (mul_done),
      .product (product)
   );

   drs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= drs_pkg::ST_IDLE;
         last_ff       <= '0;
         count_ff      <= '0;
         mean_ff       <= '0;
         ssd_ff        <= '0;
         pending_ff    <= 1'b0;
         start_time_ff <= '0;
         stddev_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         count_ff      <= count_in;
         mean_ff       <= mean_in;
         ssd_ff        <= ssd_in;
         pending_ff    <= pending_in;
         start_time_ff <= start_time_in;
         stddev_ff     <= stddev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      taken_ff <= taken_in;
      s_ff     <= s_in;
      below_ff <= below_in;
      d1_ff    <= d1_in;
      var_ff   <= var_in;
      if (rsp_load) begin
         rsp_taken_ff  <= taken_ff;
         rsp_last_ff   <= last_ff;
         rsp_mean_ff   <= mean_ff;
         rsp_stddev_ff <= stddev_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sample_taken = rsp_taken_ff;
   assign rsp_chan.last_us      = rsp_last_ff;
   assign rsp_chan.mean_fixed   = rsp_mean_ff;
   assign rsp_chan.stddev_fixed = rsp_stddev_ff;
   assign rsp_chan.sample_count = rsp_count_ff;
endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for duration_running_statistics_top
// Drives timing commands over the request channel in random bursts, predicts
// every statistics snapshot with a fixed-point Welford model held in a small
// scoreboard, and compares each response field by field. The receiver stalls
// on changing patterns, with two long hold-offs that back the block up.
// ----------------------------------------------------------------------------
module tb;
   typedef logic [drs_pkg::MODE_W-1:0]   mode_type;
   typedef logic [drs_pkg::SAMPLE_W-1:0] stamp_type;
   typedef logic [drs_pkg::ROOT_W-1:0]   root_type;

   localparam mode_type MODE_SPARE_A = 3'd5;
   localparam mode_type MODE_SPARE_C = 3'd7;

   localparam int RANDOM_ITEMS    = 1700;
   localparam int HOLD_OFF_CYCLES = 700;
   localparam int FIRST_HOLD_AT   = 200;
   localparam int SECOND_HOLD_AT  = 900;
   localparam int DRAIN_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT  = 6000;

   typedef struct packed {
      logic                          taken;
      logic [drs_pkg::SAMPLE_W-1:0]  last;
      logic [drs_pkg::MEAN_W-1:0]    mean;
      logic [drs_pkg::MEAN_W-1:0]    sdev;
      logic [drs_pkg::CNT_W-1:0]     count;
   } stats_type;

   class stats_scoreboard;
      logic [drs_pkg::SAMPLE_W-1:0] last_sample;
      logic [drs_pkg::CNT_W-1:0]    sample_cnt;
      logic [drs_pkg::MEAN_W-1:0]   mean;
      logic [drs_pkg::SSD_W-1:0]    ssd;
      logic                         start_armed;
      logic [drs_pkg::SAMPLE_W-1:0] start_stamp;
      stats_type                    snapshot_q[$];
      int                           errors;
      int                           checked;
      int                           commands;
      int                           samples;
      int                           clears;

      function new();
         clear_stats();
      endfunction

      function void clear_stats();
         last_sample = '0;
         sample_cnt  = '0;
         mean        = '0;
         ssd         = '0;
         start_armed = 1'b0;
         start_stamp = '0;
      endfunction

      function stamp_type elapsed(input stamp_type s, input stamp_type e);
         // a wrap beyond the sample width saturates
         if (drs_pkg::TIME_WIDTH > drs_pkg::SAMPLE_W &&
             (e & drs_pkg::TIME_MASK) < (s & drs_pkg::TIME_MASK))
            return '1;
         return ((e & drs_pkg::TIME_MASK) - (s & drs_pkg::TIME_MASK)) & drs_pkg::TIME_MASK;
      endfunction

      function void absorb(input stamp_type s);
         logic [63:0]  x, m64, d1, d2, step, nm, inc;
         logic [127:0] prod;
         logic [64:0]  total;
         logic         below;
         x = 64'(s) << drs_pkg::FRAC_BITS;
         m64 = 64'(mean);
         last_sample = s;
         if (sample_cnt != '1)
            sample_cnt = sample_cnt + 1'b1;
         below = x < m64;
         d1 = below ? m64 - x : x - m64;
         step = (d1 + (64'(sample_cnt) >> 1)) / 64'(sample_cnt);
         nm = below ? m64 - step : m64 + step;
         if (nm > 64'({drs_pkg::MEAN_W{1'b1}}))
            nm = 64'({drs_pkg::MEAN_W{1'b1}});
         mean = nm[drs_pkg::MEAN_W-1:0];
         d2 = (x < nm) ? nm - x : x - nm;
         prod = (128'(d1) * 128'(d2) + (128'(1) << (drs_pkg::FRAC_BITS - 1)))
                >> drs_pkg::FRAC_BITS;
         inc = (prod[127:64] != '0) ? '1 : prod[63:0];
         total = 65'(ssd) + 65'(inc);
         ssd = total[64] ? '1 : total[63:0];
      endfunction

      function logic [drs_pkg::MEAN_W-1:0] std_dev();
         logic [63:0]  div, q, rem;
         logic [127:0] rad, sq;
         root_type     r, cand;
         int           b;
         if (sample_cnt < 2)
            return '0;
         div = 64'(sample_cnt) - 64'd1;
         q = ssd / div;
         rem = ssd % div;
         if ((rem << 1) >= div)
            q = q + 64'd1;
         rad = 128'(q) << drs_pkg::FRAC_BITS;
         r = '0;
         for (b = drs_pkg::ROOT_W - 1; b >= 0; b--) begin
            cand = r | (root_type'(1) << b);
            sq = 128'(cand) * 128'(cand);
            if (sq <= rad)
               r = cand;
         end
         return r[drs_pkg::MEAN_W-1:0];
      endfunction

      function void note_command(input mode_type m, input stamp_type s,
                                 input stamp_type e, input stamp_type d);
         logic taken;
         taken = 1'b0;
         commands++;
         case (m)
            drs_pkg::MODE_START: begin
               start_stamp = s & drs_pkg::TIME_MASK;
               start_armed = 1'b1;
            end
            drs_pkg::MODE_STOP: begin
               if (start_armed) begin
                  absorb(elapsed(start_stamp, e));
                  start_armed = 1'b0;
                  taken = 1'b1;
               end
            end
            drs_pkg::MODE_ADD: begin
               absorb(d);
               taken = 1'b1;
            end
            drs_pkg::MODE_PAIR: begin
               absorb(elapsed(s, e));
               taken = 1'b1;
            end
            drs_pkg::MODE_CLEAR: begin
               clear_stats();
               clears++;
            end
            default: ;
         endcase
         if (taken)
            samples++;
         snapshot_q.push_back(stats_type'{taken, last_sample, mean, std_dev(), sample_cnt});
      endfunction

      function int outstanding();
         return snapshot_q.size();
      endfunction

      task report(input string what, input logic [63:0] got, input logic [63:0] want);
         $display("ERROR: result %0d %s: got 0x%0h, predicted 0x%0h",
                  checked, what, got, want);
         errors++;
      endtask

      task check_snapshot(input stats_type got);
         stats_type want;
         if (snapshot_q.size() == 0) begin
            report("arrived with nothing pending", 64'(got.last), 64'(0));
            return;
         end
         want = snapshot_q.pop_front();
         checked++;
         if (got.taken !== want.taken)
            report("sample_taken", 64'(got.taken), 64'(want.taken));
         if (got.last !== want.last)
            report("last_us", 64'(got.last), 64'(want.last));
         if (got.mean !== want.mean)
            report("mean_fixed", 64'(got.mean), 64'(want.mean));
         if (got.sdev !== want.sdev)
            report("stddev_fixed", 64'(got.sdev), 64'(want.sdev));
         if (got.count !== want.count)
            report("sample_count", 64'(got.count), 64'(want.count));
      endtask
   endclass

   logic clock;
   logic reset;
   int   burst_left;
   int   quiet_cycles;

   stats_scoreboard sb = new();

   drs_req_if req_chan();
   drs_rsp_if rsp_chan();

   duration_running_statistics_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic stamp_type pick_duration();
      int sel;
      sel = $urandom_range(0, 15);
      if (sel == 0)
         return $urandom();
      if (sel == 1)
         return '0;
      if (sel == 2)
         return '1;
      return $urandom_range(0, 2000) + $urandom_range(0, 1) * 100000;
   endfunction

   // Offer one command, idling between bursts; return after its transfer.
   task automatic issue(input mode_type m, input stamp_type s,
                        input stamp_type e, input stamp_type d);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 8);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= m;
      req_chan.start_us    <= s;
      req_chan.stop_us     <= e;
      req_chan.duration_us <= d;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_command(m, s, e, d);
   endtask

   // Drop valid and hold until every predicted snapshot has been checked.
   task automatic settle_results();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      issue(drs_pkg::MODE_STOP, $urandom(), 32'h0000_1000, $urandom());   // nothing armed
      for (int k = MODE_SPARE_A; k <= MODE_SPARE_C; k++)
         issue(mode_type'(k), $urandom(), $urandom(), $urandom());
      issue(drs_pkg::MODE_ADD, $urandom(), $urandom(), '0);        // one sample: no spread
      issue(drs_pkg::MODE_ADD, $urandom(), $urandom(), '1);        // squared sum saturates
      issue(drs_pkg::MODE_ADD, $urandom(), $urandom(), '0);
      issue(drs_pkg::MODE_START, 32'hFFFF_FFF0, $urandom(), $urandom());
      issue(drs_pkg::MODE_STOP, $urandom(), 32'h0000_0010, $urandom());   // timestamps wrap
      issue(drs_pkg::MODE_STOP, $urandom(), 32'h0000_0020, $urandom());
      issue(drs_pkg::MODE_CLEAR, $urandom(), $urandom(), $urandom());
      issue(drs_pkg::MODE_START, 32'd100, $urandom(), $urandom());
      issue(drs_pkg::MODE_PAIR, '1, '0, $urandom());               // keeps the armed start
      issue(drs_pkg::MODE_STOP, $urandom(), 32'd350, $urandom());
      issue(drs_pkg::MODE_ADD, $urandom(), $urandom(), 32'd1);
      issue(drs_pkg::MODE_ADD, $urandom(), $urandom(), 32'd2);
      issue(drs_pkg::MODE_ADD, $urandom(), $urandom(), 32'd2);
      issue(drs_pkg::MODE_PAIR, 32'h1234_5678, 32'h1234_5678, $urandom());
      issue(drs_pkg::MODE_START, '0, $urandom(), $urandom());
      issue(drs_pkg::MODE_START, '1, $urandom(), $urandom());      // re-arm overrides
      issue(drs_pkg::MODE_STOP, $urandom(), 32'h7FFF_FFFF, $urandom());
      issue(drs_pkg::MODE_START, $urandom(), $urandom(), $urandom());
      issue(drs_pkg::MODE_CLEAR, $urandom(), $urandom(), $urandom());   // clear disarms
      issue(drs_pkg::MODE_STOP, $urandom(), $urandom(), $urandom());
      issue(drs_pkg::MODE_ADD, $urandom(), $urandom(), '1);
      issue(drs_pkg::MODE_ADD, $urandom(), $urandom(), '1);
      issue(drs_pkg::MODE_PAIR, '0, '1, $urandom());
   endtask

   task automatic run_random(input int target);
      int        pick;
      stamp_type stamp;
      while (sb.commands < target) begin
         pick = $urandom_range(0, 99);
         stamp = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                             : $urandom();
         if (pick < 45) begin
            issue(drs_pkg::MODE_START, stamp, $urandom(), $urandom());
            if ($urandom_range(0, 9) == 0)
               issue(drs_pkg::MODE_PAIR, $urandom(), $urandom(), $urandom());
            issue(drs_pkg::MODE_STOP, $urandom(), stamp + pick_duration(), $urandom());
         end else if (pick < 70) begin
            issue(drs_pkg::MODE_ADD, $urandom(), $urandom(), pick_duration());
         end else if (pick < 85) begin
            issue(drs_pkg::MODE_PAIR, stamp,
                  ($urandom_range(0, 4) == 0) ? $urandom() : stamp + pick_duration(),
                  $urandom());
         end else if (pick < 92) begin
            issue(drs_pkg::MODE_STOP, $urandom(), $urandom(), $urandom());
         end else if (pick < 95) begin
            issue(drs_pkg::MODE_START, stamp, $urandom(), $urandom());
         end else if (pick < 98) begin
            issue(mode_type'($urandom_range(MODE_SPARE_A, MODE_SPARE_C)),
                  $urandom(), $urandom(), $urandom());
         end else begin
            issue(drs_pkg::MODE_CLEAR, $urandom(), $urandom(), $urandom());
         end
      end
   endtask

   // Receiver: stall on a pattern that changes every segment, plus two long holds.
   initial begin
      int style;
      int seg_left;
      int phase;
      int holds;
      int next_hold;
      rsp_chan.ready <= 1'b0;
      style = 0;
      seg_left = 0;
      phase = 0;
      holds = 0;
      next_hold = FIRST_HOLD_AT;
      forever begin
         @(posedge clock);
         if (holds < 2 && sb.checked >= next_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            holds++;
            next_hold = SECOND_HOLD_AT;
         end else begin
            if (seg_left == 0) begin
               style = $urandom_range(0, 3);
               seg_left = $urandom_range(32, 256);
            end
            seg_left--;
            phase++;
            case (style)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_chan.ready <= ((phase % 7) >= 2);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_snapshot(stats_type'{rsp_chan.sample_taken, rsp_chan.last_us,
                                       rsp_chan.mean_fixed, rsp_chan.stddev_fixed,
                                       rsp_chan.sample_count});
   end

   // Watchdog: end the run after a long stretch with no transfer on either side.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results pending",
                     quiet_cycles, sb.outstanding());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      burst_left = 0;
      reset = 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.mode        <= drs_pkg::MODE_START;
      req_chan.start_us    <= '0;
      req_chan.stop_us     <= '0;
      req_chan.duration_us <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      settle_results();
      run_random(sb.commands + RANDOM_ITEMS / 2);
      settle_results();
      run_random(sb.commands + RANDOM_ITEMS / 2);
      settle_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d commands: %0d samples taken, %0d clears, %0d snapshots checked",
               sb.commands, sb.samples, sb.clears, sb.checked);
      $display("Included wrapped timestamps, stray stops, spare modes and long receiver holds");
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
